// ===== hw/rtl/wbps_pkg.sv =====
package wbps_pkg;

  localparam int MAX_PATTERN_BYTES_DEF = 16;
  localparam int PATTERN_SLOTS = 16;
  localparam int LEN_W = 5;
  localparam int CNT_W = 32;
  localparam int ADDR_W = 64;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW  = 3'd0,
    CFG_PATTERN_HIGH = 3'd1,
    CFG_WILDCARD     = 3'd2,
    CFG_LENGTH       = 3'd3,
    CFG_BASE_ADDR    = 3'd4
  } cfg_idx_t;

  // Pattern settings seen by every cell of the window chain.
  typedef struct packed {
    logic [PATTERN_SLOTS*8-1:0] pattern;
    logic [PATTERN_SLOTS-1:0]   wild;
    logic [LEN_W-1:0]           len;
  } cell_cfg_t;

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] offset;
  } result_t;

endpackage

// ===== hw/rtl/wbps_cell.sv =====
module wbps_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                clk,
  input  logic                shift,
  input  wbps_pkg::cell_cfg_t cfg,
  input  logic [7:0]          byte_in,
  output logic [7:0]          byte_out,
  output logic                hit
);
  import wbps_pkg::*;

  localparam logic [6:0] IDX = 7'(CELL_IDX);

  logic [7:0]       byte_r;
  logic             active;
  logic [LEN_W-1:0] pos_full;
  logic [3:0]       pos;
  logic [7:0]       pat_byte;

  // The window needs no reset: a comparison only counts once the region has
  // delivered as many bytes as the pattern is long.
  always_ff @(posedge clk) begin
    if (shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

  // This cell sees the byte that becomes its content, i.e. the window after
  // the incoming transaction; it faces pattern position len-1-IDX.
  always_comb begin
    active   = {2'b00, cfg.len} > IDX;
    pos_full = cfg.len - 5'd1 - IDX[LEN_W-1:0];
    pos      = pos_full[3:0];
    pat_byte = cfg.pattern[{pos, 3'b000} +: 8];
    hit      = !active || cfg.wild[pos] || (byte_in == pat_byte);
  end

endmodule

// ===== hw/rtl/wbps_out_buf.sv =====
module wbps_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wbps_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output wbps_pkg::result_t head
);
  import wbps_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t head_r, head_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    head_nxt       = head_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        head_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        head_nxt      = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign head      = head_r;

`ifndef SYNTH
  a_skid_implies_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a result while the output slot is empty");

  a_stalled_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && !skid_valid_r && push) |=> skid_valid_r)
    else $error("result pushed behind a stalled output was not kept");
`endif

endmodule

// ===== hw/rtl/wildcard_byte_pattern_search.sv =====
// Wildcard byte pattern search.
// The input channel (in_valid, in_stall, in_data_byte, in_last_byte) takes one
// byte of a scanned region per transaction; in_last_byte marks the region end.
// Configuration (pattern bytes, wildcard mask, pattern length, region base
// address) is written via cfg_write_en, cfg_index and cfg_wdata; the user must
// write it only while no result is pending; the block does not enforce it.
// A row of cells holds the most recent bytes and compares each against the
// pattern position it faces, so every byte is checked in the cycle in which
// it is accepted. One byte is taken per clock cycle while in_stall is low.
// The output channel (out_valid, out_stall, out_found, out_match_address)
// carries at most one transaction per region: the first match with its
// address, or found low with address zero at a region end without a match.
// A result is registered in the output buffer before it reaches the output.
// Results go into a two-entry buffer; in_stall rises only when both entries
// are occupied, so a stalled receiver holds up the input after two results.
// Synchronous reset clears the region state, the buffer valid flags and the
// configuration; the pattern length resets to one, the rest to zero.
module wildcard_byte_pattern_search #(
  parameter int MAX_PATTERN_BYTES = wbps_pkg::MAX_PATTERN_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_found,
  output logic [wbps_pkg::ADDR_W-1:0]        out_match_address,
  input  logic                               cfg_write_en,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import wbps_pkg::*;

  localparam int LEN_LIMIT = (MAX_PATTERN_BYTES < PATTERN_SLOTS) ?
                             MAX_PATTERN_BYTES : PATTERN_SLOTS;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LEN_LIMIT);

  logic [63:0]            pat_low_r, pat_high_r;
  logic [PATTERN_SLOTS-1:0] wild_r;
  logic [LEN_W-1:0]       len_r;
  logic [ADDR_W-1:0]      base_r;

  logic [CNT_W-1:0]       seen_r, seen_nxt, seen_inc;
  logic                   reported_r, reported_nxt;

  cell_cfg_t              cell_cfg;
  logic [LEN_W-1:0]       len_eff;
  logic [7:0]             win [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hits;
  logic                   accept, hit, push, buf_full;
  result_t                push_data, head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      wild_r     <= '0;
      len_r      <= LEN_W'(1);
      base_r     <= '0;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:  pat_low_r  <= cfg_wdata;
        CFG_PATTERN_HIGH: pat_high_r <= cfg_wdata;
        CFG_WILDCARD:     wild_r     <= cfg_wdata[PATTERN_SLOTS-1:0];
        CFG_LENGTH:       len_r      <= cfg_wdata[LEN_W-1:0];
        CFG_BASE_ADDR:    base_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = len_r;
    end
    cell_cfg.pattern = {pat_high_r, pat_low_r};
    cell_cfg.wild    = wild_r;
    cell_cfg.len     = len_eff;
  end

  assign accept = in_valid && !in_stall;

  genvar g;
  generate
    for (g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_cell
      logic [7:0] cell_in;
      if (g == 0) begin : g_head
        assign cell_in = in_data_byte;
      end else begin : g_link
        assign cell_in = win[g-1];
      end
      wbps_cell #(
        .CELL_IDX (g)
      ) u_cell (
        .clk      (clk),
        .shift    (accept),
        .cfg      (cell_cfg),
        .byte_in  (cell_in),
        .byte_out (win[g]),
        .hit      (hits[g])
      );
    end
  endgenerate

  always_comb begin
    seen_inc     = (&seen_r) ? seen_r : seen_r + CNT_W'(1);
    hit          = !reported_r && (seen_inc >= CNT_W'(len_eff)) && (&hits);
    push         = accept && (hit || (in_last_byte && !reported_r));
    push_data.found  = hit;
    push_data.offset = seen_inc - CNT_W'(len_eff);
    seen_nxt     = seen_r;
    reported_nxt = reported_r;
    if (accept) begin
      if (in_last_byte) begin
        seen_nxt     = '0;
        reported_nxt = 1'b0;
      end else begin
        seen_nxt     = seen_inc;
        reported_nxt = reported_r || hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      reported_r <= 1'b0;
    end else begin
      seen_r     <= seen_nxt;
      reported_r <= reported_nxt;
    end
  end

  wbps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign in_stall  = buf_full;
  assign out_found = head.found;

  // The user must not change the base address while a result is pending; the
  // block does not enforce this. The sum is formed on the output side.
  assign out_match_address = head.found ? base_r + {32'd0, head.offset} : '0;

`ifndef SYNTH
  a_region_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> (seen_r == '0 && !reported_r))
    else $error("region state not cleared after the last byte");

  a_match_marks_region: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && hit && !in_last_byte) |=> reported_r)
    else $error("match reported without marking the region");
`endif

endmodule
